// ----- src/rs485_hdt_pkg.sv -----
// Shared types and constants of the RS485 half-duplex transaction sequencer.
package rs485_hdt_pkg;

  localparam int unsigned MaxFrame   = 256;
  localparam int unsigned FlushLimit = 20;

  localparam int unsigned FrameW  = $clog2(MaxFrame + 1);
  localparam int unsigned FlushW  = $clog2(FlushLimit + 1);
  localparam int unsigned TurnW   = 16;
  localparam int unsigned TmoW    = 17;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned SendExtra = 2;
  localparam int unsigned RecvExtra = 5;

  localparam logic [FrameW-1:0] MaxFrameVal = FrameW'(MaxFrame);
  localparam logic [FlushW-1:0] FlushLimitVal = FlushW'(FlushLimit);
  localparam logic [TmoW-1:0] EmptyMax = {TmoW{1'b1}};

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhSend   = 3'd1,
    PhFinish = 3'd2,
    PhFlush  = 3'd3,
    PhRecv   = 3'd4,
    PhDone   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrTimeout = 2'd1,
    ErrOverrun = 2'd2
  } err_e;

  typedef enum logic {
    OpPoll  = 1'b0,
    OpStart = 1'b1
  } op_e;

  typedef enum logic {
    CfgTurnaround = 1'b0,
    CfgTimeout    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
    logic       rx_avail;
    logic       tx_idle;
    logic       tx_space;
    logic [7:0] recv_len;
    logic [7:0] send_len;
  } in_item_t;

  // Packed so that the first field lands in the highest bits.
  typedef struct packed {
    logic [7:0] store_byte;
    logic [7:0] store_index;
    logic       store_strobe;
    logic [7:0] write_index;
    logic       write_strobe;
    logic       drive_enable;
    err_e       error_code;
    phase_e     phase;
  } result_t;

  typedef struct packed {
    logic       we;
    cfg_idx_e   idx;
    logic [CfgW-1:0] wdata;
  } cfg_wr_t;

endpackage

// ----- src/rs485_half_duplex_transaction.sv -----
// Top level of the RS485 half-duplex master transaction sequencer.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready   | tdata 32b status beat, tuser op
//  m_axis   | out | m_axis_tvalid/m_axis_tready   | tdata 32b result beat
//  cfg      | in  | cfg_we_i (no wait)            | cfg_idx_i, cfg_wdata_i
//
// One result beat per input beat; a beat is accepted every cycle when the sink
// keeps up. A beat passes through the input register, then the sequencer
// logic into the result register. Reset restores idle phase, no error,
// turnaround 1 and timeout 100. A stalled result holds the pipeline and the
// input register then holds one more beat before s_axis_tready drops.
module rs485_half_duplex_transaction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // send_len[7:0], recv_len[15:8], tx_space[16], tx_idle[17], rx_avail[18],
  // rx_byte[26:19], zero fill [31:27]
  input  logic [31:0] s_axis_tdata,
  // op (0 poll, 1 start)
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // phase[2:0], error_code[4:3], drive_enable[5], write_strobe[6],
  // write_index[14:7], store_strobe[15], store_index[23:16], store_byte[31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [rs485_hdt_pkg::CfgW-1:0] cfg_wdata_i
);

  rs485_hdt_pkg::in_item_t in_item, core_item;
  rs485_hdt_pkg::result_t  core_res, out_res;
  rs485_hdt_pkg::cfg_wr_t  cfg_wr;
  logic                    in_valid, out_free, step;

  assign in_item.op       = rs485_hdt_pkg::op_e'(s_axis_tuser);
  assign in_item.send_len = s_axis_tdata[7:0];
  assign in_item.recv_len = s_axis_tdata[15:8];
  assign in_item.tx_space = s_axis_tdata[16];
  assign in_item.tx_idle  = s_axis_tdata[17];
  assign in_item.rx_avail = s_axis_tdata[18];
  assign in_item.rx_byte  = s_axis_tdata[26:19];

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.idx   = rs485_hdt_pkg::cfg_idx_e'(cfg_idx_i);
  assign cfg_wr.wdata = cfg_wdata_i;

  // Advance when a beat is held and the result register can take it.
  assign step = in_valid && out_free;

  rs485_hdt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (in_valid),
    .take_i  (step),
    .item_o  (core_item)
  );

  rs485_hdt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .step_i (step),
    .item_i (core_item),
    .res_o  (core_res)
  );

  rs485_hdt_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

// ----- src/rs485_hdt_in_stage.sv -----
// Input register: captures one beat and holds it until the sequencer takes it.
module rs485_hdt_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  rs485_hdt_pkg::in_item_t item_i,
  output logic                    valid_o,
  input  logic                    take_i,
  output rs485_hdt_pkg::in_item_t item_o
);

  logic                    valid_q, valid_d;
  rs485_hdt_pkg::in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/rs485_hdt_core.sv -----
// Transaction state, configuration registers and the per-beat next-state logic.
module rs485_hdt_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rs485_hdt_pkg::cfg_wr_t  cfg_i,
  input  logic                    step_i,
  input  rs485_hdt_pkg::in_item_t item_i,
  output rs485_hdt_pkg::result_t  res_o
);

  localparam int unsigned FW = rs485_hdt_pkg::FrameW;
  localparam int unsigned LW = rs485_hdt_pkg::FlushW;
  localparam int unsigned TW = rs485_hdt_pkg::TurnW;
  localparam int unsigned OW = rs485_hdt_pkg::TmoW;

  logic [TW-1:0] turn_q;
  logic [OW-1:0] tmo_q;

  rs485_hdt_pkg::phase_e phase_q, phase_d;
  rs485_hdt_pkg::err_e   err_q, err_d;
  logic [FW-1:0] send_pos_q, send_pos_d;
  logic [FW-1:0] send_tot_q, send_tot_d;
  logic [FW-1:0] recv_cnt_q, recv_cnt_d;
  logic [FW-1:0] recv_tot_q, recv_tot_d;
  logic [TW-1:0] wait_q, wait_d;
  logic          wait_ld_q, wait_ld_d;
  logic [OW-1:0] empty_q, empty_d;
  logic [LW-1:0] flush_q, flush_d;

  logic [FW-1:0] send_sum, recv_sum;
  logic [TW-1:0] wait_v;
  logic [OW-1:0] empty_inc;
  logic [LW-1:0] flush_inc;
  logic [FW-1:0] recv_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q <= TW'(1);
      tmo_q  <= OW'(100);
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        rs485_hdt_pkg::CfgTurnaround: turn_q <= cfg_i.wdata[TW-1:0];
        rs485_hdt_pkg::CfgTimeout:    tmo_q  <= cfg_i.wdata[OW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rs485_hdt_pkg::PhIdle;
      err_q      <= rs485_hdt_pkg::ErrNone;
      send_pos_q <= '0;
      send_tot_q <= '0;
      recv_cnt_q <= '0;
      recv_tot_q <= '0;
      wait_q     <= '0;
      wait_ld_q  <= 1'b0;
      empty_q    <= '0;
      flush_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      send_pos_q <= send_pos_d;
      send_tot_q <= send_tot_d;
      recv_cnt_q <= recv_cnt_d;
      recv_tot_q <= recv_tot_d;
      wait_q     <= wait_d;
      wait_ld_q  <= wait_ld_d;
      empty_q    <= empty_d;
      flush_q    <= flush_d;
    end
  end

  // Lengths are at most 255, so the sums fit FW bits before the clamp.
  assign send_sum  = FW'(item_i.send_len) + FW'(rs485_hdt_pkg::SendExtra);
  assign recv_sum  = FW'(item_i.recv_len) + FW'(rs485_hdt_pkg::RecvExtra);
  assign wait_v    = wait_ld_q ? wait_q : turn_q;
  assign empty_inc = (empty_q == rs485_hdt_pkg::EmptyMax) ? empty_q : empty_q + OW'(1);
  assign flush_inc = flush_q + LW'(1);
  assign recv_inc  = recv_cnt_q + FW'(1);

  always_comb begin
    phase_d    = phase_q;
    err_d      = err_q;
    send_pos_d = send_pos_q;
    send_tot_d = send_tot_q;
    recv_cnt_d = recv_cnt_q;
    recv_tot_d = recv_tot_q;
    wait_d     = wait_q;
    wait_ld_d  = wait_ld_q;
    empty_d    = empty_q;
    flush_d    = flush_q;
    res_o      = '0;

    if (item_i.op == rs485_hdt_pkg::OpStart) begin
      send_tot_d = (send_sum > rs485_hdt_pkg::MaxFrameVal) ?
                   rs485_hdt_pkg::MaxFrameVal : send_sum;
      recv_tot_d = (recv_sum > rs485_hdt_pkg::MaxFrameVal) ?
                   rs485_hdt_pkg::MaxFrameVal : recv_sum;
      send_pos_d = '0;
      recv_cnt_d = '0;
      wait_ld_d  = 1'b0;
      wait_d     = '0;
      empty_d    = '0;
      flush_d    = '0;
      err_d      = rs485_hdt_pkg::ErrNone;
      phase_d    = rs485_hdt_pkg::PhSend;
    end else begin
      case (phase_q)
        rs485_hdt_pkg::PhSend: begin
          if (item_i.tx_space) begin
            if (send_pos_q < send_tot_q) begin
              res_o.write_strobe = 1'b1;
              res_o.write_index  = send_pos_q[7:0];
              send_pos_d         = send_pos_q + FW'(1);
              wait_ld_d          = 1'b0;
            end else begin
              phase_d = rs485_hdt_pkg::PhFinish;
            end
          end
        end
        rs485_hdt_pkg::PhFinish: begin
          if (item_i.tx_idle) begin
            wait_ld_d = 1'b1;
            if (wait_v == '0) begin
              wait_d     = '0;
              recv_cnt_d = '0;
              empty_d    = '0;
              flush_d    = '0;
              phase_d    = rs485_hdt_pkg::PhFlush;
            end else begin
              wait_d = wait_v - TW'(1);
            end
          end
        end
        rs485_hdt_pkg::PhFlush: begin
          if (item_i.rx_avail) begin
            flush_d = flush_inc;
            if (flush_inc >= rs485_hdt_pkg::FlushLimitVal) begin
              err_d   = rs485_hdt_pkg::ErrOverrun;
              phase_d = rs485_hdt_pkg::PhRecv;
            end
          end else begin
            phase_d = rs485_hdt_pkg::PhRecv;
          end
        end
        rs485_hdt_pkg::PhRecv: begin
          if (item_i.rx_avail) begin
            empty_d            = '0;
            res_o.store_strobe = 1'b1;
            res_o.store_index  = recv_cnt_q[7:0];
            res_o.store_byte   = item_i.rx_byte;
            recv_cnt_d         = recv_inc;
            if (recv_inc >= recv_tot_q) begin
              phase_d = rs485_hdt_pkg::PhDone;
            end
          end else begin
            empty_d = empty_inc;
            if (empty_inc >= tmo_q) begin
              err_d   = rs485_hdt_pkg::ErrTimeout;
              phase_d = rs485_hdt_pkg::PhDone;
            end
          end
        end
        default: ;
      endcase
    end

    res_o.phase        = phase_d;
    res_o.error_code   = err_d;
    res_o.drive_enable = (phase_d == rs485_hdt_pkg::PhSend) ||
                         (phase_d == rs485_hdt_pkg::PhFinish);
  end

endmodule

// ----- src/rs485_hdt_out_stage.sv -----
// Result register: holds one result beat until the sink takes it.
module rs485_hdt_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  rs485_hdt_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output rs485_hdt_pkg::result_t res_o
);

  logic                   valid_q, valid_d;
  rs485_hdt_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- src/rs485_hdt_checker.sv -----
// Port-level checks of the RS485 transaction sequencer, bound to the top level.
module rs485_hdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [2:0] ph;
  assign ph = m_axis_tdata[2:0];

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |->
      m_axis_tdata[5] && ph == 3'(rs485_hdt_pkg::PhSend))
    else $error("frame byte sent outside sending phase");

  a_store_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15] |->
      !m_axis_tdata[5] &&
      (ph == 3'(rs485_hdt_pkg::PhRecv) || ph == 3'(rs485_hdt_pkg::PhDone)))
    else $error("reply byte stored outside receiving");

  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[5] ==
        (ph == 3'(rs485_hdt_pkg::PhSend) || ph == 3'(rs485_hdt_pkg::PhFinish)))
    else $error("drive enable disagrees with phase");

endmodule

bind rs485_half_duplex_transaction rs485_hdt_checker u_rs485_hdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
